>>> hdl/dstq_pkg.sv
// ----------------------------------------------------------------------------
// dstq_pkg: shared types and constants of the deadline sorted timer queue
// Operation and status codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package dstq_pkg;

  localparam int TIMER_SLOTS_DEFAULT = 16;

  localparam int SEC_W  = 32;
  localparam int USEC_W = 20;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_CNT_W  = 5;

  localparam logic [USEC_W:0] USEC_PER_SEC = 21'd1000000;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_CANCEL     = 2'd1,
    OP_CANCEL_ALL = 2'd2,
    OP_POLL       = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CARRY,
    S_POP,
    S_INS_RD,
    S_INS_CMP,
    S_FIND_RD,
    S_FIND_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DRAIN_RD,
    S_DRAIN_WR,
    S_POLL_RD,
    S_POLL_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> hdl/dstq_ram.sv
// ----------------------------------------------------------------------------
// dstq_ram: generic simple dual port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module dstq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/deadline_sorted_timer_queue.sv
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue: timer slots kept in deadline order
// Register, cancel, cancel-all and poll on a fixed pool of timer slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_*: s_tuser carries the operation, s_tdata the
//   current time, the delay and the cancel handle. Every input beat gives
//   exactly one result beat on m_*: status, new slot, expiry flag, expired
//   slot and the number of queued timers afterwards.
//   The queue lives in one RAM of (slot, deadline) entries sorted by
//   position; the free slots live in a second RAM used as a LIFO stack.
//   One deadline comparator and a small sequencer walk the queue, one RAM
//   read plus one compare or move at each step.
//   Work from accept to result:
//     register   : carry, pop a free slot, move later entries toward the tail
//     cancel     : find the slot from the head, move entries behind it forward
//     cancel all : push every queued slot on the free stack, head first
//     poll       : compare the head with now; if due, drop it and close the gap
//   Full pool, inactive handle or empty queue skip straight to the result.
//   One item is worked on at a time; s_tready is high only while idle.
//   A result waits in the output register while the next beat is accepted;
//   a stalled receiver holds the sequencer at its last step.
//   Reset empties the queue and puts every slot on the free stack, highest
//   index on top; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_sorted_timer_queue #(
  parameter int TIMER_SLOTS = dstq_pkg::TIMER_SLOTS_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [31:0] now_sec, [51:32] now_usec, [83:52] delay_sec,
  // [103:84] delay_usec, [107:104] target_slot, [111:108] zero
  input  wire logic [111:0] s_tdata,
  // [1:0] operation
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [1:0] status, [5:2] new_slot, [6] expired, [10:7] expired_slot,
  // [15:11] active_count
  output logic [15:0]       m_tdata
);

  localparam int SW = $clog2(TIMER_SLOTS);
  localparam int CW = $clog2(TIMER_SLOTS + 1);
  localparam int TW = dstq_pkg::SEC_W + dstq_pkg::USEC_W;
  localparam int EW = SW + TW;

  dstq_pkg::state_t state, state_next;

  // Item registers
  logic [dstq_pkg::SEC_W-1:0]  now_sec;
  logic [dstq_pkg::USEC_W-1:0] now_usec;
  logic [SW-1:0]               tgt;
  logic [dstq_pkg::SEC_W+1:0]  sum_sec, sum_sec_next;
  logic [dstq_pkg::USEC_W:0]   sum_usec, sum_usec_next;
  logic [SW-1:0]               slot, slot_next;

  // Queue and pool bookkeeping
  logic [CW-1:0]          p, p_next;
  logic [CW-1:0]          cnt, cnt_next;
  logic [CW-1:0]          ft, ft_next;
  logic [TIMER_SLOTS-1:0] active;
  logic [TIMER_SLOTS-1:0] fs_written;

  // Result under construction
  dstq_pkg::status_t res_status, res_status_next;
  logic [SW-1:0]     res_new, res_new_next;
  logic              res_exp, res_exp_next;
  logic [SW-1:0]     res_exp_slot, res_exp_slot_next;
  logic              out_load;

  // RAM ports
  logic          q_we;
  logic [SW-1:0] q_waddr, q_raddr;
  logic [EW-1:0] q_wdata, q_rdata;
  logic          f_we;
  logic [SW-1:0] f_waddr, f_raddr;
  logic [SW-1:0] f_wdata, f_rdata;

  logic          act_set, act_clr;
  logic [SW-1:0] act_idx;

  logic [SW-1:0]               e_slot;
  logic [dstq_pkg::SEC_W-1:0]  e_sec;
  logic [dstq_pkg::USEC_W-1:0] e_usec;
  logic [dstq_pkg::SEC_W-1:0]  key_sec;
  logic [EW-1:0]               new_entry;
  logic [SW-1:0]               fidx;
  logic [SW-1:0]               pop_slot;
  logic [dstq_pkg::SEC_W-1:0]  cmp_sec;
  logic [dstq_pkg::USEC_W-1:0] cmp_usec;
  logic                        cmp_earlier;
  logic                        tgt_ok;
  logic [CW-1:0]               p_inc;
  dstq_pkg::op_t               in_op;

  assign e_slot = q_rdata[EW-1:TW];
  assign e_sec  = q_rdata[TW-1:dstq_pkg::USEC_W];
  assign e_usec = q_rdata[dstq_pkg::USEC_W-1:0];

  // Saturate seconds that overflowed 32 bits
  assign key_sec   = (sum_sec[dstq_pkg::SEC_W+1:dstq_pkg::SEC_W] != 2'b00) ?
                     '1 : sum_sec[dstq_pkg::SEC_W-1:0];
  assign new_entry = {slot, key_sec, sum_usec[dstq_pkg::USEC_W-1:0]};

  assign fidx     = SW'(ft - CW'(1));
  assign pop_slot = fs_written[fidx] ? f_rdata : fidx;
  assign f_raddr  = fidx;
  assign p_inc    = p + CW'(1);

  // Shared deadline comparator: operand strictly earlier than queue entry
  assign cmp_sec     = (state == dstq_pkg::S_POLL_CMP) ? now_sec  : key_sec;
  assign cmp_usec    = (state == dstq_pkg::S_POLL_CMP) ? now_usec :
                       sum_usec[dstq_pkg::USEC_W-1:0];
  assign cmp_earlier = (cmp_sec != e_sec) ? (cmp_sec < e_sec) : (cmp_usec < e_usec);

  assign in_op  = dstq_pkg::op_t'(s_tuser);
  assign tgt_ok = (32'(s_tdata[107:104]) < TIMER_SLOTS) &&
                  active[SW'(s_tdata[107:104])];

  assign s_tready = (state == dstq_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dstq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    p_next            = p;
    cnt_next          = cnt;
    ft_next           = ft;
    sum_sec_next      = sum_sec;
    sum_usec_next     = sum_usec;
    slot_next         = slot;
    res_status_next   = res_status;
    res_new_next      = res_new;
    res_exp_next      = res_exp;
    res_exp_slot_next = res_exp_slot;
    out_load          = 1'b0;
    q_we              = 1'b0;
    q_waddr           = p[SW-1:0];
    q_wdata           = new_entry;
    q_raddr           = p[SW-1:0];
    f_we              = 1'b0;
    f_waddr           = ft[SW-1:0];
    f_wdata           = e_slot;
    act_set           = 1'b0;
    act_clr           = 1'b0;
    act_idx           = e_slot;

    unique case (state)
      dstq_pkg::S_IDLE: begin
        if (s_tvalid) begin
          res_status_next   = dstq_pkg::STAT_OK;
          res_new_next      = '0;
          res_exp_next      = 1'b0;
          res_exp_slot_next = '0;
          sum_sec_next      = {2'b00, s_tdata[31:0]} + {2'b00, s_tdata[83:52]};
          sum_usec_next     = {1'b0, s_tdata[51:32]} + {1'b0, s_tdata[103:84]};
          p_next            = '0;
          unique case (in_op)
            dstq_pkg::OP_REGISTER: begin
              if (ft == '0) begin
                res_status_next = dstq_pkg::STAT_NO_FREE;
                state_next      = dstq_pkg::S_DONE;
              end else begin
                state_next = dstq_pkg::S_CARRY;
              end
            end
            dstq_pkg::OP_CANCEL: begin
              if (!tgt_ok) begin
                res_status_next = dstq_pkg::STAT_NOT_ACTIVE;
                state_next      = dstq_pkg::S_DONE;
              end else begin
                state_next = dstq_pkg::S_FIND_RD;
              end
            end
            dstq_pkg::OP_CANCEL_ALL: begin
              state_next = (cnt == '0) ? dstq_pkg::S_DONE : dstq_pkg::S_DRAIN_RD;
            end
            dstq_pkg::OP_POLL: begin
              state_next = (cnt == '0) ? dstq_pkg::S_DONE : dstq_pkg::S_POLL_RD;
            end
            default: state_next = dstq_pkg::S_DONE;
          endcase
        end
      end

      dstq_pkg::S_CARRY: begin
        // Reduce microseconds one second at a time
        if (sum_usec >= dstq_pkg::USEC_PER_SEC) begin
          sum_usec_next = sum_usec - dstq_pkg::USEC_PER_SEC;
          sum_sec_next  = sum_sec + 34'd1;
        end else begin
          state_next = dstq_pkg::S_POP;
        end
      end

      dstq_pkg::S_POP: begin
        slot_next    = pop_slot;
        res_new_next = pop_slot;
        ft_next      = ft - CW'(1);
        act_set      = 1'b1;
        act_idx      = pop_slot;
        p_next       = cnt;
        state_next   = dstq_pkg::S_INS_RD;
      end

      dstq_pkg::S_INS_RD: begin
        if (p == '0) begin
          q_we       = 1'b1;
          cnt_next   = cnt + CW'(1);
          state_next = dstq_pkg::S_DONE;
        end else begin
          q_raddr    = SW'(p - CW'(1));
          state_next = dstq_pkg::S_INS_CMP;
        end
      end

      dstq_pkg::S_INS_CMP: begin
        q_we = 1'b1;
        if (cmp_earlier) begin
          // Move the later entry one place toward the tail
          q_wdata    = q_rdata;
          p_next     = p - CW'(1);
          state_next = dstq_pkg::S_INS_RD;
        end else begin
          cnt_next   = cnt + CW'(1);
          state_next = dstq_pkg::S_DONE;
        end
      end

      dstq_pkg::S_FIND_RD: begin
        state_next = dstq_pkg::S_FIND_CMP;
      end

      dstq_pkg::S_FIND_CMP: begin
        if (e_slot == tgt) begin
          f_we       = 1'b1;
          ft_next    = ft + CW'(1);
          act_clr    = 1'b1;
          state_next = dstq_pkg::S_SHIFT_RD;
        end else begin
          p_next     = p_inc;
          state_next = dstq_pkg::S_FIND_RD;
        end
      end

      dstq_pkg::S_SHIFT_RD: begin
        if (p_inc >= cnt) begin
          cnt_next   = cnt - CW'(1);
          state_next = dstq_pkg::S_DONE;
        end else begin
          q_raddr    = p_inc[SW-1:0];
          state_next = dstq_pkg::S_SHIFT_WR;
        end
      end

      dstq_pkg::S_SHIFT_WR: begin
        q_we       = 1'b1;
        q_wdata    = q_rdata;
        p_next     = p_inc;
        state_next = dstq_pkg::S_SHIFT_RD;
      end

      dstq_pkg::S_DRAIN_RD: begin
        state_next = dstq_pkg::S_DRAIN_WR;
      end

      dstq_pkg::S_DRAIN_WR: begin
        // Push head first, so the old tail ends on top
        f_we    = 1'b1;
        ft_next = ft + CW'(1);
        act_clr = 1'b1;
        if (p_inc == cnt) begin
          cnt_next   = '0;
          state_next = dstq_pkg::S_DONE;
        end else begin
          p_next     = p_inc;
          state_next = dstq_pkg::S_DRAIN_RD;
        end
      end

      dstq_pkg::S_POLL_RD: begin
        state_next = dstq_pkg::S_POLL_CMP;
      end

      dstq_pkg::S_POLL_CMP: begin
        if (!cmp_earlier) begin
          res_exp_next      = 1'b1;
          res_exp_slot_next = e_slot;
          f_we              = 1'b1;
          ft_next           = ft + CW'(1);
          act_clr           = 1'b1;
          state_next        = dstq_pkg::S_SHIFT_RD;
        end else begin
          state_next = dstq_pkg::S_DONE;
        end
      end

      dstq_pkg::S_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = dstq_pkg::S_IDLE;
        end
      end

      default: state_next = dstq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p          <= '0;
      cnt        <= '0;
      ft         <= CW'(TIMER_SLOTS);
      active     <= '0;
      fs_written <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      p   <= p_next;
      cnt <= cnt_next;
      ft  <= ft_next;
      if (act_set) begin
        active[act_idx] <= 1'b1;
      end
      if (act_clr) begin
        active[act_idx] <= 1'b0;
      end
      if (f_we) begin
        fs_written[f_waddr] <= 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      now_sec  <= s_tdata[31:0];
      now_usec <= s_tdata[51:32];
      tgt      <= SW'(s_tdata[107:104]);
    end
    sum_sec      <= sum_sec_next;
    sum_usec     <= sum_usec_next;
    slot         <= slot_next;
    res_status   <= res_status_next;
    res_new      <= res_new_next;
    res_exp      <= res_exp_next;
    res_exp_slot <= res_exp_slot_next;
    if (out_load) begin
      m_tdata <= {dstq_pkg::OUT_CNT_W'(cnt),
                  dstq_pkg::OUT_SLOT_W'(res_exp_slot),
                  res_exp,
                  dstq_pkg::OUT_SLOT_W'(res_new),
                  res_status};
    end
  end

  dstq_ram #(
    .WIDTH(EW),
    .DEPTH(TIMER_SLOTS)
  ) u_queue_ram (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  dstq_ram #(
    .WIDTH(SW),
    .DEPTH(TIMER_SLOTS)
  ) u_free_ram (
    .clk  (clk),
    .we   (f_we),
    .waddr(f_waddr),
    .wdata(f_wdata),
    .raddr(f_raddr),
    .rdata(f_rdata)
  );

`ifndef ASSERT_OFF
  // Every slot is either queued or on the free stack
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (state == dstq_pkg::S_IDLE) |-> (32'(ft) + 32'(cnt) == TIMER_SLOTS))
    else $error("free stack and queue do not account for every slot");

  a_active_count: assert property (@(posedge clk) disable iff (rst)
    (state == dstq_pkg::S_IDLE) |-> ($countones(active) == 32'(cnt)))
    else $error("active flags disagree with queue length");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == dstq_pkg::S_POP) |-> (ft != '0))
    else $error("slot taken from an empty free stack");
`endif

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of the deadline sorted timer queue
// Streams register, cancel, cancel-all and poll beats through the queue and
// checks every result beat against an in-bench model of the sorted queue and
// its LIFO free-slot stack. Both sides idle in random bursts, and the result
// side holds off once for a long stretch so that the queue backs up.
// ----------------------------------------------------------------------------
module tb;
  import dstq_pkg::*;

  localparam int SLOTS       = 16;
  localparam int TOTAL_ITEMS = 1900;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int CALM_TAIL   = 150;
  localparam int LONG_HOLD   = 400;
  localparam int HOLD_AFTER  = 500;
  localparam logic [SEC_W-1:0]  SEC_MAX  = 32'hFFFF_FFFF;
  localparam logic [USEC_W-1:0] USEC_MAX = 20'hF_FFFF;

  typedef struct {
    op_t               op;
    logic [SEC_W-1:0]  now_s;
    logic [USEC_W-1:0] now_u;
    logic [SEC_W-1:0]  dly_s;
    logic [USEC_W-1:0] dly_u;
    logic [3:0]        target;
  } timer_req_t;

  typedef struct {
    status_t    status;
    logic [3:0] new_slot;
    logic       expired;
    logic [3:0] exp_slot;
    logic [4:0] count;
  } timer_resp_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;

  deadline_sorted_timer_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the timer pool
  logic [SEC_W-1:0]  dl_sec      [SLOTS];
  logic [USEC_W-1:0] dl_usec     [SLOTS];
  logic              slot_busy   [SLOTS];
  logic [3:0]        queue_order [SLOTS];
  int                queue_len;
  logic [3:0]        free_slots  [SLOTS];
  int                free_len;

  timer_req_t  req_pending[$];
  timer_resp_t resp_expected[$];

  int  mismatches    = 0;
  int  resp_checked  = 0;
  int  cycles        = 0;
  int  gap_pct       = 0;
  int  in_gap        = 0;
  int  out_gap       = 0;
  int  hold_left     = 0;
  bit  long_hold_done = 1'b0;
  bit  in_taken      = 1'b0;

  timer_req_t  drive_req;
  timer_req_t  seen_req;
  timer_resp_t seen_want;
  timer_resp_t head_want;

  function automatic bit earlier(logic [SEC_W-1:0] a_s, logic [USEC_W-1:0] a_u,
                                 logic [SEC_W-1:0] b_s, logic [USEC_W-1:0] b_u);
    if (a_s != b_s) return a_s < b_s;
    return a_u < b_u;
  endfunction

  // drop one queue position and push its slot back on the free stack
  task automatic unlink_position(input int pos);
    logic [3:0] slot;
    slot = queue_order[pos];
    for (int p = pos; p + 1 < queue_len; p++) queue_order[p] = queue_order[p + 1];
    queue_len--;
    slot_busy[slot] = 1'b0;
    if (free_len < SLOTS) begin
      free_slots[free_len] = slot;
      free_len++;
    end
  endtask

  task automatic advance_timer_queue(input timer_req_t r, output timer_resp_t e);
    logic [33:0]       secs;
    logic [USEC_W:0]   usec;
    logic [3:0]        slot;
    int                pos;
    e = '{STAT_OK, 4'd0, 1'b0, 4'd0, 5'd0};
    case (r.op)
      OP_REGISTER: begin
        if (free_len == 0) begin
          e.status = STAT_NO_FREE;
        end else begin
          secs = {2'b00, r.now_s} + {2'b00, r.dly_s};
          usec = {1'b0, r.now_u} + {1'b0, r.dly_u};
          while (usec >= USEC_PER_SEC) begin
            usec = usec - USEC_PER_SEC;
            secs = secs + 34'd1;
          end
          if (secs > {2'b00, SEC_MAX}) secs = {2'b00, SEC_MAX};
          free_len--;
          slot = free_slots[free_len];
          dl_sec[slot]    = secs[SEC_W-1:0];
          dl_usec[slot]   = usec[USEC_W-1:0];
          slot_busy[slot] = 1'b1;
          // insert behind every entry due at the same time or earlier
          pos = 0;
          while (pos < queue_len &&
                 !earlier(secs[SEC_W-1:0], usec[USEC_W-1:0],
                          dl_sec[queue_order[pos]], dl_usec[queue_order[pos]]))
            pos++;
          for (int p = queue_len; p > pos; p--) queue_order[p] = queue_order[p - 1];
          queue_order[pos] = slot;
          queue_len++;
          e.new_slot = slot;
        end
      end
      OP_CANCEL: begin
        if (!slot_busy[r.target]) begin
          e.status = STAT_NOT_ACTIVE;
        end else begin
          pos = 0;
          while (pos < queue_len && queue_order[pos] != r.target) pos++;
          if (pos < queue_len) unlink_position(pos);
        end
      end
      OP_CANCEL_ALL: begin
        while (queue_len > 0) unlink_position(0);
      end
      OP_POLL: begin
        if (queue_len > 0 &&
            !earlier(r.now_s, r.now_u, dl_sec[queue_order[0]], dl_usec[queue_order[0]])) begin
          e.expired  = 1'b1;
          e.exp_slot = queue_order[0];
          unlink_position(0);
        end
      end
    endcase
    e.count = queue_len[4:0];
  endtask

  task automatic add_item(input op_t op, input logic [SEC_W-1:0] ns,
                          input logic [USEC_W-1:0] nu, input logic [SEC_W-1:0] ds,
                          input logic [USEC_W-1:0] du, input logic [3:0] tg);
    timer_req_t r;
    r.op     = op;
    r.now_s  = ns;
    r.now_u  = nu;
    r.dly_s  = ds;
    r.dly_u  = du;
    r.target = tg;
    req_pending.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("tb: result %0d: %s is %0d, model says %0d", resp_checked, what, got, want);
    mismatches++;
  endtask

  // timeout and idle-rate phases
  always @(posedge clk) begin
    cycles++;
    if (cycles % 256 == 0) begin
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 3;
        2: gap_pct = 10;
        default: gap_pct = 30;
      endcase
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // input beats
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the beat until it is taken
    end else if (in_gap > 0) begin
      in_gap--;
      s_tvalid <= 1'b0;
    end else if (req_pending.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (req_pending.size() > CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
      in_gap = $urandom_range(1, 16) - 1;
      s_tvalid <= 1'b0;
    end else begin
      drive_req = req_pending.pop_front();
      s_tdata  <= {4'd0, drive_req.target, drive_req.dly_u, drive_req.dly_s,
                   drive_req.now_u, drive_req.now_s};
      s_tuser  <= drive_req.op;
      s_tvalid <= 1'b1;
    end
  end

  // result side ready, with bursts and one long hold
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!long_hold_done && resp_checked >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      m_tready <= 1'b0;
    end else if (req_pending.size() > CALM_TAIL && $urandom_range(0, 99) < gap_pct) begin
      out_gap = $urandom_range(1, 16) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // check results first, then predict the beat taken at this edge
  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (resp_expected.size() == 0) begin
        report_mismatch("unexpected result beat", {16'd0, m_tdata}, 32'd0);
      end else begin
        head_want = resp_expected.pop_front();
        if (m_tdata[1:0] !== head_want.status)
          report_mismatch("status", 32'(m_tdata[1:0]), 32'(head_want.status));
        if (m_tdata[5:2] !== head_want.new_slot)
          report_mismatch("new_slot", 32'(m_tdata[5:2]), 32'(head_want.new_slot));
        if (m_tdata[6] !== head_want.expired)
          report_mismatch("expired", 32'(m_tdata[6]), 32'(head_want.expired));
        if (m_tdata[10:7] !== head_want.exp_slot)
          report_mismatch("expired_slot", 32'(m_tdata[10:7]), 32'(head_want.exp_slot));
        if (m_tdata[15:11] !== head_want.count)
          report_mismatch("active_count", 32'(m_tdata[15:11]), 32'(head_want.count));
        resp_checked++;
      end
    end
    if (in_taken) begin
      seen_req.op     = op_t'(s_tuser);
      seen_req.now_s  = s_tdata[31:0];
      seen_req.now_u  = s_tdata[51:32];
      seen_req.dly_s  = s_tdata[83:52];
      seen_req.dly_u  = s_tdata[103:84];
      seen_req.target = s_tdata[107:104];
      advance_timer_queue(seen_req, seen_want);
      resp_expected.push_back(seen_want);
    end
  end

  initial begin
    logic [SEC_W-1:0] t_sec;
    int               t_usec;
    int               seg;
    int               w;
    logic [SEC_W-1:0] ds;
    logic [USEC_W-1:0] du;

    rst      = 1'b1;

    for (int i = 0; i < SLOTS; i++) begin
      dl_sec[i]      = '0;
      dl_usec[i]     = '0;
      slot_busy[i]   = 1'b0;
      queue_order[i] = '0;
      free_slots[i]  = i[3:0];
    end
    free_len  = SLOTS;
    queue_len = 0;

    // empty queue: poll, inactive cancel, cancel-all
    add_item(OP_POLL, SEC_MAX, USEC_MAX, 32'd0, 20'd0, 4'd0);
    add_item(OP_CANCEL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd15);
    add_item(OP_CANCEL_ALL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd0);
    // zero deadline, saturated seconds, double carry, equal deadline, exact carry
    add_item(OP_REGISTER, 32'd0, 20'd0, 32'd0, 20'd0, 4'd0);
    add_item(OP_REGISTER, SEC_MAX, 20'd999999, SEC_MAX, USEC_MAX, 4'd0);
    add_item(OP_REGISTER, 32'd0, USEC_MAX, 32'd0, USEC_MAX, 4'd0);
    add_item(OP_REGISTER, 32'd0, 20'd0, 32'd0, 20'd0, 4'd0);
    add_item(OP_REGISTER, 32'd0, 20'd1, 32'd0, 20'd999999, 4'd0);
    for (int i = 0; i < 11; i++)
      add_item(OP_REGISTER, $urandom_range(0, 3), USEC_W'($urandom_range(0, 999999)),
               $urandom_range(0, 3), USEC_W'($urandom_range(0, 999999)), 4'd0);
    // pool full
    add_item(OP_REGISTER, 32'd0, 20'd0, 32'd1, 20'd0, 4'd0);
    // cancel an active slot, then the same one again
    add_item(OP_CANCEL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd13);
    add_item(OP_CANCEL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd13);
    // head due exactly now
    add_item(OP_POLL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd0);
    add_item(OP_CANCEL_ALL, 32'd0, 20'd0, 32'd0, 20'd0, 4'd0);
    // early poll: seconds decide before microseconds
    add_item(OP_REGISTER, 32'd0, 20'd0, 32'd5, 20'd0, 4'd0);
    add_item(OP_POLL, 32'd4, 20'd999999, 32'd0, 20'd0, 4'd0);

    t_sec  = $urandom_range(0, 100);
    t_usec = 0;
    while (req_pending.size() < TOTAL_ITEMS) begin
      seg = $urandom_range(0, 9);
      if (seg == 0) begin
        // noise: every field random
        for (int i = 0; i < 10; i++)
          add_item(op_t'($urandom_range(0, 3)), $urandom,
                   USEC_W'($urandom_range(0, USEC_MAX)), $urandom,
                   USEC_W'($urandom_range(0, USEC_MAX)), 4'($urandom_range(0, 15)));
      end else if (seg == 1) begin
        // burst of registers runs the pool dry
        for (int i = 0; i < 18; i++)
          add_item(OP_REGISTER, t_sec, USEC_W'(t_usec), $urandom_range(0, 2),
                   USEC_W'($urandom_range(0, 999999)), 4'($urandom_range(0, 15)));
      end else begin
        if (seg == 2) t_sec = SEC_MAX - $urandom_range(0, 3);
        if (seg == 3) t_sec = $urandom_range(0, 100);
        for (int i = 0; i < 30; i++) begin
          t_usec += $urandom_range(0, 400000);
          if (t_usec >= 1000000) begin
            t_usec -= 1000000;
            if (t_sec != SEC_MAX) t_sec++;
          end
          w = $urandom_range(0, 99);
          if (w < 40) begin
            ds = (w < 3) ? $urandom : $urandom_range(0, 1);
            du = ($urandom_range(0, 15) == 0) ? USEC_W'($urandom_range(1000000, USEC_MAX))
                                              : USEC_W'($urandom_range(0, 999999));
            if ($urandom_range(0, 15) == 0) begin
              ds = '0;
              du = '0;
            end
            add_item(OP_REGISTER, t_sec, USEC_W'(t_usec), ds, du,
                     4'($urandom_range(0, 15)));
          end else if (w < 75) begin
            add_item(OP_POLL, t_sec, USEC_W'(t_usec), $urandom,
                     USEC_W'($urandom_range(0, USEC_MAX)), 4'($urandom_range(0, 15)));
          end else if (w < 97) begin
            add_item(OP_CANCEL, $urandom, USEC_W'($urandom_range(0, USEC_MAX)), $urandom,
                     USEC_W'($urandom_range(0, USEC_MAX)), 4'($urandom_range(0, 15)));
          end else begin
            add_item(OP_CANCEL_ALL, $urandom, USEC_W'($urandom_range(0, USEC_MAX)),
                     $urandom, USEC_W'($urandom_range(0, USEC_MAX)),
                     4'($urandom_range(0, 15)));
          end
        end
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (req_pending.size() != 0 || s_tvalid || resp_expected.size() != 0)
      @(posedge clk);
    repeat (60) @(posedge clk);

    if (mismatches == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

>>> deadline_sorted_timer_queue.f
hdl/dstq_pkg.sv
hdl/dstq_ram.sv
hdl/deadline_sorted_timer_queue.sv
dv/tb.sv
